// ===== rtl/scp_pkg.sv =====
// Shared types and constants for the serial register command parser.
// Used by scp_parse and serial_register_command_parser_core; no dependencies.
`timescale 1ns / 1ps

package scp_pkg;

	// Character codes
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_TILDE = 8'h7e;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CASE_BIT = 8'h20;

	// Accumulator wide enough for 0xffff * 16 + 15
	localparam int unsigned ACC_W = 20;
	localparam logic [ACC_W-1:0] MAX_REG   = ACC_W'(8'hff);
	localparam logic [ACC_W-1:0] MAX_VALUE = ACC_W'(16'hffff);

	// Parser states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_READ_REG  = 5'b00010,
		ST_WRITE_REG = 5'b00100,
		ST_WRITE_VAL = 5'b01000,
		ST_ERROR     = 5'b10000
	} state_t;

	// Result action codes
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_ERROR = 2'd3
	} action_t;

	// Parse context carried from byte to byte
	typedef struct packed {
		state_t      st;
		logic [7:0]  reg_number;
		logic        reg_present;
		logic [15:0] value_number;
		logic        value_present;
		logic        hex_mode;
	} ctx_t;

	// One result item
	typedef struct packed {
		logic [15:0] write_value;
		logic [7:0]  reg_addr;
		action_t     action;
		logic        line_end;
		logic [7:0]  echo_char;
	} result_t;

endpackage

// ===== rtl/scp_parse.sv =====
// Combinational step of the command parser: one byte plus the current
// parse context gives the next context and one result item. Uses scp_pkg.
`timescale 1ns / 1ps

module scp_parse import scp_pkg::*; (
	input  logic [7:0] char_code,
	input  ctx_t       ctx,
	output ctx_t       ctx_nxt,
	output result_t    res
);

	logic              is_line;
	logic              printable;
	logic [7:0]        lc;
	logic              in_val;
	logic              pres;
	logic [ACC_W-1:0]  d;
	logic              is_x;
	logic              is_dec;
	logic              is_hexl;
	logic [3:0]        dig;
	logic              skip;
	logic              fail;
	logic              commit;

	// Byte classification
	always_comb begin
		is_line   = (char_code == CH_LF) || (char_code == CH_CR);
		printable = (char_code >= CH_SPACE) && (char_code < CH_DEL);
		lc        = char_code | CASE_BIT;
		is_x      = (lc == CH_LC_X);
		is_dec    = (lc >= CH_ZERO) && (lc <= CH_NINE);
		is_hexl   = (lc >= CH_LC_A) && (lc <= CH_LC_F) && ctx.hex_mode;
		// letters a..f have low nibble 1..6
		dig       = is_dec ? lc[3:0] : (lc[3:0] + 4'd9);
		in_val    = (ctx.st == ST_WRITE_VAL);
	end

	// Next context and result
	always_comb begin
		ctx_nxt = ctx;
		res     = '0;
		pres    = in_val ? ctx.value_present : ctx.reg_present;
		d       = in_val ? ACC_W'(ctx.value_number) : ACC_W'(ctx.reg_number);
		skip    = 1'b0;
		fail    = 1'b0;
		commit  = 1'b0;

		if (is_line) begin
			// line end: report and go back to idle
			res.line_end = 1'b1;
			if (ctx.st == ST_READ_REG && ctx.reg_present) begin
				res.action   = ACT_READ;
				res.reg_addr = ctx.reg_number;
			end else if (ctx.st == ST_WRITE_VAL && ctx.value_present) begin
				res.action      = ACT_WRITE;
				res.reg_addr    = ctx.reg_number;
				res.write_value = ctx.value_number;
			end else if (ctx.st != ST_IDLE) begin
				res.action = ACT_ERROR;
			end
			ctx_nxt.st = ST_IDLE;
		end else if (!printable) begin
			res.echo_char = CH_TILDE;
			ctx_nxt.st    = ST_ERROR;
		end else begin
			res.echo_char = char_code;
			unique case (ctx.st)
				ST_IDLE: begin
					// command letter, case sensitive
					if (char_code == CH_R)
						ctx_nxt.st = ST_READ_REG;
					else if (char_code == CH_W)
						ctx_nxt.st = ST_WRITE_REG;
					else
						ctx_nxt.st = ST_ERROR;
					ctx_nxt.reg_number    = '0;
					ctx_nxt.reg_present   = 1'b0;
					ctx_nxt.value_number  = '0;
					ctx_nxt.value_present = 1'b0;
					ctx_nxt.hex_mode      = 1'b0;
				end
				ST_READ_REG, ST_WRITE_REG, ST_WRITE_VAL: begin
					// leading space skip, first digit, leading zero check
					if (!pres && !is_x) begin
						if (lc == CH_SPACE) begin
							skip = 1'b1;
						end else begin
							d    = '0;
							pres = 1'b1;
						end
					end else if (pres && d == '0 && !is_x && lc != CH_COMMA &&
					             !ctx.hex_mode) begin
						fail = 1'b1;
					end

					if (!skip && !fail) begin
						if (is_dec) begin
							d = ctx.hex_mode ? ((d << 4) + ACC_W'(dig))
							                 : ((d << 3) + (d << 1) + ACC_W'(dig));
							commit = 1'b1;
						end else if (is_hexl) begin
							d      = (d << 4) + ACC_W'(dig);
							commit = 1'b1;
						end else if (is_x && pres && d == '0 && !ctx.hex_mode) begin
							// "0x" prefix: restart the number in hex
							d                = '0;
							pres             = 1'b0;
							ctx_nxt.hex_mode = 1'b1;
							commit           = 1'b1;
						end else if (ctx.st == ST_WRITE_REG && lc == CH_COMMA) begin
							if (d > MAX_REG) begin
								ctx_nxt.st = ST_ERROR;
							end else begin
								ctx_nxt.reg_number  = d[7:0];
								ctx_nxt.reg_present = 1'b1;
								ctx_nxt.hex_mode    = 1'b0;
								ctx_nxt.st          = ST_WRITE_VAL;
							end
						end else begin
							fail = 1'b1;
						end
					end

					// store with range check
					if (fail) begin
						ctx_nxt.st = ST_ERROR;
					end else if (commit) begin
						if (in_val) begin
							if (d > MAX_VALUE) begin
								ctx_nxt.st = ST_ERROR;
							end else begin
								ctx_nxt.value_number  = d[15:0];
								ctx_nxt.value_present = pres;
							end
						end else begin
							if (d > MAX_REG) begin
								ctx_nxt.st = ST_ERROR;
							end else begin
								ctx_nxt.reg_number  = d[7:0];
								ctx_nxt.reg_present = pres;
							end
						end
					end
				end
				default: begin
					// error state and unused codes: echo only
					ctx_nxt.st = ST_ERROR;
				end
			endcase
		end
	end

endmodule

// ===== rtl/serial_register_command_parser_core.sv =====
// Top level of the serial register command parser: input register, parse
// context registers and result register around scp_parse. Uses scp_pkg.
`timescale 1ns / 1ps

// Byte-serial parser for the line commands "R<reg>" and "W<reg>,<value>".
// One byte enters per transaction on the s_ side and one result leaves per
// transaction on the m_ side. Throughput is one byte per clock while the m_
// side takes results; a byte's result is loaded from the input register into
// the result register once that register is empty or m_tready is high, and
// the only per-byte path is the single-pass parse step from the input register
// into the context and result registers.
// Each result echoes its byte ('~' for a non-printable one) but on CR or LF;
// then it sets tlast and reports a read request, a write request, a command
// error or no action in tuser, with the register and value in tdata.

module serial_register_command_parser_core import scp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] echo_char, [15:8] reg_addr, [31:16] write_value
	output logic        m_tlast,   // line_end
	output logic [1:0]  m_tuser    // [1:0] action
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       valid_s2;
	result_t    res_s2;
	ctx_t       ctx_q;
	ctx_t       ctx_nxt;
	result_t    res_nxt;
	logic       advance;

	// Stage handshake
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			char_s1 <= s_tdata;
	end

	// Parse step
	scp_parse u_parse (
		.char_code (char_s1),
		.ctx       (ctx_q),
		.ctx_nxt   (ctx_nxt),
		.res       (res_nxt)
	);

	// Parse context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.st            <= ST_IDLE;
			ctx_q.reg_number    <= '0;
			ctx_q.reg_present   <= 1'b0;
			ctx_q.value_number  <= '0;
			ctx_q.value_present <= 1'b0;
			ctx_q.hex_mode      <= 1'b0;
		end else if (valid_s1 && advance) begin
			ctx_q <= ctx_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance)
			res_s2 <= res_nxt;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.write_value, res_s2.reg_addr, res_s2.echo_char};
	assign m_tlast  = res_s2.line_end;
	assign m_tuser  = res_s2.action;

	// Checks
	a_action_on_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ACT_NONE |-> m_tlast)
		else $error("action reported without line end");

	a_line_end_echo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00)
		else $error("echo byte not cleared on line end");

	a_idle_after_line: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && (char_s1 == CH_LF || char_s1 == CH_CR)
		|=> ctx_q.st == ST_IDLE)
		else $error("parser not idle after line end");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

endmodule

// ===== tb/serial_register_command_parser_core_tb.sv =====
// Self-checking testbench for serial_register_command_parser_core: byte stream
// in, per-byte results checked against a built-in parser model. Uses scp_pkg.
`timescale 1ns / 1ps

module serial_register_command_parser_core_tb;
	import scp_pkg::*;

	localparam int unsigned REG_LIMIT      = 255;
	localparam int unsigned VALUE_LIMIT    = 65535;
	localparam int          PHASE_BYTES    = 375;
	localparam int          TAIL_CYCLES    = 10;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          REPORT_LIMIT   = 10;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;

	serial_register_command_parser_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// Stimulus and expectation stores
	logic [7:0] pending_bytes[$];
	logic [7:0] line_buf[$];
	result_t    pending_results[$];

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	logic byte_taken   = 1'b0;

	int error_count  = 0;
	int bytes_in     = 0;
	int lines_seen   = 0;
	int reads_seen   = 0;
	int writes_seen  = 0;
	int errors_seen  = 0;
	int quiet_cycles = 0;

	// Parser model state
	state_t      cur_state = ST_IDLE;
	logic [7:0]  acc_reg   = '0;
	logic        reg_seen  = 1'b0;
	logic [15:0] acc_val   = '0;
	logic        val_seen  = 1'b0;
	logic        in_hex    = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Fold one lower-cased byte into the register or value number
	function automatic void fold_number_byte(input logic [7:0] c);
		logic        in_val;
		logic        seen;
		logic [31:0] d;
		logic        is_x;
		in_val = (cur_state == ST_WRITE_VAL);
		seen   = in_val ? val_seen : reg_seen;
		d      = in_val ? 32'(acc_val) : 32'(acc_reg);
		is_x   = (c == CH_LC_X);

		// skip spaces before the first digit; refuse a leading zero
		if (!seen && !is_x) begin
			if (c == CH_SPACE)
				return;
			d    = 0;
			seen = 1'b1;
		end else if (seen && d == 0 && !is_x && c != CH_COMMA && !in_hex) begin
			cur_state = ST_ERROR;
			return;
		end

		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = d * (in_hex ? 32'd16 : 32'd10) + (32'(c) - 32'(CH_ZERO));
		end else if (c >= CH_LC_A && c <= CH_LC_F && in_hex) begin
			d = d * 32'd16 + (32'(c) - 32'(CH_LC_A) + 32'd10);
		end else if (is_x && seen && d == 0 && !in_hex) begin
			d      = 0;
			seen   = 1'b0;
			in_hex = 1'b1;
		end else if (cur_state == ST_WRITE_REG && c == CH_COMMA) begin
			if (d > REG_LIMIT) begin
				cur_state = ST_ERROR;
			end else begin
				acc_reg   = d[7:0];
				reg_seen  = 1'b1;
				in_hex    = 1'b0;
				cur_state = ST_WRITE_VAL;
			end
			return;
		end else begin
			cur_state = ST_ERROR;
			return;
		end

		// range check and commit
		if (in_val) begin
			if (d > VALUE_LIMIT) begin
				cur_state = ST_ERROR;
			end else begin
				acc_val  = d[15:0];
				val_seen = seen;
			end
		end else begin
			if (d > REG_LIMIT) begin
				cur_state = ST_ERROR;
			end else begin
				acc_reg  = d[7:0];
				reg_seen = seen;
			end
		end
	endfunction

	// Expected result of one received byte; advances the model state
	function automatic result_t parse_byte(input logic [7:0] code);
		result_t    r;
		logic [7:0] c;
		r = '0;

		// line end reports the command
		if (code == CH_LF || code == CH_CR) begin
			r.line_end = 1'b1;
			if (cur_state == ST_READ_REG && reg_seen) begin
				r.action   = ACT_READ;
				r.reg_addr = acc_reg;
			end else if (cur_state == ST_WRITE_VAL && val_seen) begin
				r.action      = ACT_WRITE;
				r.reg_addr    = acc_reg;
				r.write_value = acc_val;
			end else if (cur_state != ST_IDLE) begin
				r.action = ACT_ERROR;
			end
			cur_state = ST_IDLE;
			return r;
		end

		// non-printable bytes echo as tilde and spoil the line
		c = code;
		if (code < CH_SPACE || code >= CH_DEL) begin
			c         = CH_TILDE;
			cur_state = ST_ERROR;
		end
		r.echo_char = c;

		if (cur_state == ST_IDLE) begin
			if (c == CH_R)
				cur_state = ST_READ_REG;
			else if (c == CH_W)
				cur_state = ST_WRITE_REG;
			else
				cur_state = ST_ERROR;
			acc_reg  = '0;
			reg_seen = 1'b0;
			acc_val  = '0;
			val_seen = 1'b0;
			in_hex   = 1'b0;
		end else if (cur_state == ST_READ_REG || cur_state == ST_WRITE_REG ||
				cur_state == ST_WRITE_VAL) begin
			fold_number_byte(c | CASE_BIT);
		end
		return r;
	endfunction

	// Mostly in range, sometimes at the edges or beyond the limit
	function automatic int unsigned pick_number(input int unsigned limit);
		case ($urandom_range(9))
			0:       return 0;
			1:       return limit;
			2:       return limit + 1 + $urandom_range(limit * 4);
			default: return $urandom_range(limit);
		endcase
	endfunction

	task automatic add_number(input int unsigned v);
		string      s;
		logic [7:0] c;
		repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
			line_buf.push_back(CH_SPACE);
		if ($urandom_range(2) == 0) begin
			// hex with mixed case and an occasional space after the prefix
			line_buf.push_back(CH_ZERO);
			line_buf.push_back($urandom_range(1) ? CH_LC_X : (CH_LC_X & ~CASE_BIT));
			if ($urandom_range(7) == 0)
				line_buf.push_back(CH_SPACE);
			s = $sformatf("%0h", v);
			foreach (s[i]) begin
				c = s[i];
				if (c >= CH_LC_A && $urandom_range(1))
					c = c & ~CASE_BIT;
				line_buf.push_back(c);
			end
		end else begin
			s = $sformatf("%0d", v);
			foreach (s[i])
				line_buf.push_back(s[i]);
		end
	endtask

	// Move the line in line_buf to the send queue, with a line end
	task automatic commit_line(input logic [7:0] ender);
		line_buf.push_back(ender);
		foreach (line_buf[i])
			pending_bytes.push_back(line_buf[i]);
		line_buf.delete();
	endtask

	// One random line: mostly well-formed commands, the rest broken or noise
	task automatic gen_line();
		int kind;
		kind = $urandom_range(19);
		line_buf.delete();
		if (kind <= 6) begin
			line_buf.push_back(CH_R);
			add_number(pick_number(REG_LIMIT));
		end else if (kind <= 13) begin
			line_buf.push_back(CH_W);
			add_number(pick_number(REG_LIMIT));
			line_buf.push_back(CH_COMMA);
			add_number(pick_number(VALUE_LIMIT));
		end else begin
			case (kind)
				14: begin
					// command with no number at all
					line_buf.push_back($urandom_range(1) ? CH_R : CH_W);
					repeat ($urandom_range(2))
						line_buf.push_back(CH_SPACE);
					if ($urandom_range(1)) begin
						line_buf.push_back(CH_ZERO);
						line_buf.push_back(CH_LC_X);
					end
				end
				15: begin
					// leading zero
					line_buf.push_back(CH_R);
					line_buf.push_back(CH_ZERO);
					add_number(pick_number(REG_LIMIT));
				end
				16: begin
					// random printable first byte
					line_buf.push_back(8'($urandom_range(32, 126)));
					add_number(pick_number(REG_LIMIT));
				end
				17: begin
					repeat ($urandom_range(1, 6))
						line_buf.push_back(8'($urandom_range(255)));
				end
				18: begin
					// empty register or missing value
					line_buf.push_back(CH_W);
					if ($urandom_range(1)) begin
						line_buf.push_back(CH_COMMA);
						add_number(pick_number(VALUE_LIMIT));
					end else begin
						add_number(pick_number(REG_LIMIT));
						line_buf.push_back(CH_COMMA);
					end
				end
				default: begin
					// stray printable byte between digits
					line_buf.push_back(CH_R);
					add_number($urandom_range(25));
					line_buf.push_back(8'($urandom_range(32, 126)));
					add_number($urandom_range(25));
				end
			endcase
		end
		// corrupt a few lines by inserting or dropping a byte
		if ($urandom_range(11) == 0)
			line_buf.insert($urandom_range(line_buf.size()), 8'($urandom_range(255)));
		else if ($urandom_range(15) == 0 && line_buf.size() > 1)
			line_buf.delete($urandom_range(line_buf.size() - 1));
		commit_line($urandom_range(1) ? CH_CR : CH_LF);
	endtask

	// Generate one pacing phase and wait for its bytes to be taken
	task automatic run_phase(input int gap_pct, input int stall_pct);
		int start_count;
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		start_count    = pending_bytes.size();
		while (pending_bytes.size() - start_count < PHASE_BYTES)
			gen_line();
		while (pending_bytes.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("[%0t] ERROR: %s", $time, msg);
	endtask

	// Driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (!s_tvalid || byte_taken) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_bytes.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor and scoreboard: sample on the rising edge
	always @(posedge clk) begin : check_side
		result_t want;
		byte_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			// input transaction
			if (s_tvalid && s_tready) begin
				pending_results.push_back(parse_byte(s_tdata));
				bytes_in++;
			end

			// output transaction
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					flag_error($sformatf("unexpected result data=%h last=%b user=%0d",
						m_tdata, m_tlast, m_tuser));
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[7:0] !== want.echo_char || m_tdata[15:8] !== want.reg_addr ||
							m_tdata[31:16] !== want.write_value ||
							m_tlast !== want.line_end || m_tuser !== want.action)
						flag_error($sformatf({"echo %h/%h reg %h/%h value %h/%h ",
							"last %b/%b action %0d/%0d (expected/actual)"},
							want.echo_char, m_tdata[7:0], want.reg_addr, m_tdata[15:8],
							want.write_value, m_tdata[31:16], want.line_end, m_tlast,
							want.action, m_tuser));
					if (want.line_end) begin
						lines_seen++;
						case (want.action)
							ACT_READ:  reads_seen++;
							ACT_WRITE: writes_seen++;
							ACT_ERROR: errors_seen++;
							default:   ;
						endcase
					end
				end
			end

			// watchdog on cycles with no transaction on either side
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] Watchdog: no transaction in %0d cycles", $time, quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Reset, stimulus and end of run
	initial begin
		arst_n   = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed lines: empty line, missing number, empty register with
		// hex value and space after prefix, non-printable extremes, prefix
		// with no digit, misplaced x, skipped space and largest register
		commit_line(CH_LF);
		line_buf.push_back(CH_R);
		commit_line(CH_CR);
		line_buf = '{CH_W, CH_COMMA, CH_ZERO, CH_LC_X & ~CASE_BIT, CH_SPACE,
			CH_LC_F, CH_LC_F & ~CASE_BIT};
		commit_line(CH_LF);
		line_buf = '{8'h00, 8'hff};
		commit_line(CH_CR);
		line_buf = '{CH_R, CH_ZERO, CH_LC_X};
		commit_line(CH_LF);
		line_buf = '{CH_R, CH_LC_X, CH_ZERO + 8'd1};
		commit_line(CH_CR);
		line_buf = '{CH_R, CH_SPACE, CH_ZERO + 8'd2, CH_ZERO + 8'd5, CH_ZERO + 8'd5};
		commit_line(CH_LF);

		// random lines under four pacing phases
		run_phase(0, 0);
		run_phase(64, 0);
		run_phase(0, 64);
		run_phase(6, 6);

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d bytes in %0d lines: %0d reads, %0d writes, %0d rejected",
			bytes_in, lines_seen, reads_seen, writes_seen, errors_seen);
		$display("Pacing: free flow, sender gaps, receiver stalls and both; %0d bad results",
			error_count);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/scp_pkg.sv
rtl/scp_parse.sv
rtl/serial_register_command_parser_core.sv
tb/serial_register_command_parser_core_tb.sv
